// ===== design/stids_pkg.sv =====
// ----------------------------------------------------------------------------
// stids_pkg: shared types and constants of the sorted table core
// Table depth, field widths, operation and status codes, cell control types.
// ----------------------------------------------------------------------------
package stids_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // operation codes; the unused code behaves as a search
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

  // per-cell compare outcome back to the controller
  typedef struct packed {
    logic lt;     // occupied and entry below the operand
    logic first;  // first cell not below the operand
    logic eq;     // occupied and entry equal to the operand
  } cell_sts_t;

endpackage

// ===== design/stids_cell.sv =====
// ----------------------------------------------------------------------------
// stids_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast operand and shifts data to
// or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module stids_cell
  import stids_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic                    occ_i,
  input  logic                    left_lt_i,
  input  logic signed [VAL_W-1:0] left_entry_i,
  input  logic signed [VAL_W-1:0] right_entry_i,
  output logic signed [VAL_W-1:0] entry_o,
  output cell_sts_t               sts_o
);

  logic signed [VAL_W-1:0] entry_q;
  logic signed [VAL_W-1:0] entry_d;

  always_comb begin
    sts_o.lt    = occ_i && (entry_q < ctl_i.value);
    sts_o.eq    = occ_i && (entry_q == ctl_i.value);
    sts_o.first = left_lt_i && !sts_o.lt;
  end

  // cells below the insert or delete point keep their entry
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && !sts_o.lt) begin
      entry_d = left_lt_i ? ctl_i.value : left_entry_i;
    end else if (ctl_i.del && !sts_o.lt) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== design/sorted_table_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_search_core: sorted table with insert/delete/search
// Keeps up to DEPTH signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
//  channel  | direction | word contents (low bit first)
//  s_axis   | in        | action[1:0], value[33:2], zero pad to 40 bits
//  m_axis   | out       | status[1:0], hit[2], position[6:3], occupancy[11:7]
//
// one word per cycle unless a result waits on m_axis: every cell compares its
// entry with the operand and shifts in the same cycle, the result lands in the
// output register and is valid in the cycle after input acceptance
// reset clears the entry count and the output valid flag; entries and output data need none
// input stalls only while a finished result waits on m_axis
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_search_core
  import stids_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // action[1:0], value[33:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status, hit, position, occupancy
);

  logic                    in_acc;
  logic [1:0]              act;
  logic signed [VAL_W-1:0] val;

  logic [CNT_W-1:0] held_q;
  logic [CNT_W-1:0] held_d;

  logic             out_vld_q;
  logic [1:0]       out_st_q;
  logic [1:0]       out_st_d;
  logic             out_hit_q;
  logic             out_hit_d;
  logic [POS_W-1:0] out_pos_q;
  logic [POS_W-1:0] out_pos_d;
  logic [CNT_W-1:0] out_cnt_q;

  cell_ctl_t               ctl;
  cell_sts_t               sts   [DEPTH];
  logic signed [VAL_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        first_vec;
  logic [DEPTH-1:0]        eq_vec;
  logic [POS_W-1:0]        pos;
  logic                    full;
  logic                    found;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign act           = s_axis_tdata[1:0];
  assign val           = $signed(s_axis_tdata[VAL_W+1:2]);

  assign full  = (held_q == CNT_W'(DEPTH));
  assign found = |eq_vec;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i]       = (held_q > CNT_W'(i));
      first_vec[i] = sts[i].first;
      eq_vec[i]    = sts[i].eq;
    end
  end

  // encode the one-hot insert/match point
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        pos = pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    ctl.value = val;
    ctl.ins   = 1'b0;
    ctl.del   = 1'b0;
    held_d    = held_q;
    out_st_d  = ST_DONE;
    out_hit_d = 1'b1;
    out_pos_d = pos;
    if (act == ACT_INSERT) begin
      if (full) begin
        out_st_d  = ST_FULL;
        out_hit_d = 1'b0;
        out_pos_d = '0;
      end else begin
        ctl.ins = in_acc;
        held_d  = held_q + CNT_W'(1);
      end
    end else if (!found) begin
      out_st_d  = ST_ABSENT;
      out_hit_d = 1'b0;
      out_pos_d = '0;
    end else if (act == ACT_DELETE) begin
      ctl.del = in_acc;
      held_d  = held_q - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lt    = sts[g-1].lt;
      assign left_entry = entry[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_entry = entry[g];
    end else begin : g_mid
      assign right_entry = entry[g+1];
    end

    stids_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (occ[g]),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry[g]),
      .sts_o         (sts[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        held_q    <= held_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_st_q  <= out_st_d;
      out_hit_q <= out_hit_d;
      out_pos_q <= out_pos_d;
      out_cnt_q <= held_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_cnt_q, out_pos_q, out_hit_q, out_st_q};

  // count never passes the table depth
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // at most one cell marks the insert/match point
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_vec))
    else $error("several cells claim the insert point");

  // an accepted insert on a table with room grows the count by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (act == ACT_INSERT) && !full |=> held_q == $past(held_q) + CNT_W'(1))
    else $error("insert did not grow the table");

  // a hit result always carries the done status
  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_hit_q |-> out_st_q == ST_DONE)
    else $error("hit reported with a failure status");

endmodule
